/* rtl/rtspd_pkg.sv */
// shared types, constants and helper functions of the rtsp stream demux
package rtspd_pkg;

  localparam int BODY_LIMIT_DEF = 65536;
  localparam int MAX_RES        = 5;
  localparam int FIFO_DEPTH     = 8;

  // parser modes
  localparam logic [2:0] M_HUNT   = 3'd0;
  localparam logic [2:0] M_BIN    = 3'd1;
  localparam logic [2:0] M_STATUS = 3'd2;
  localparam logic [2:0] M_HEADER = 3'd3;
  localparam logic [2:0] M_BODY   = 3'd4;
  localparam logic [2:0] M_TAIL   = 3'd5;

  // status line phases
  localparam logic [3:0] S_SLASH = 4'd0;
  localparam logic [3:0] S_MAJ0  = 4'd1;
  localparam logic [3:0] S_MAJ   = 4'd2;
  localparam logic [3:0] S_MIN0  = 4'd3;
  localparam logic [3:0] S_MIN   = 4'd4;
  localparam logic [3:0] S_VTAIL = 4'd5;
  localparam logic [3:0] S_GAP   = 4'd6;
  localparam logic [3:0] S_POS   = 4'd7;
  localparam logic [3:0] S_NEG   = 4'd8;
  localparam logic [3:0] S_CODE  = 4'd9;
  localparam logic [3:0] S_CTAIL = 4'd10;

  // header line phases
  localparam logic [3:0] H_LEAD  = 4'd0;
  localparam logic [3:0] H_NAME  = 4'd1;
  localparam logic [3:0] H_SKIP  = 4'd2;
  localparam logic [3:0] H_VLEAD = 4'd3;
  localparam logic [3:0] H_VSIGN = 4'd4;
  localparam logic [3:0] H_VNUM  = 4'd5;

  localparam logic [3:0] NAME_LEN = 4'd14;
  localparam logic [3:0] NO_MATCH = 4'd15;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_STATUS = 2'd1;
  localparam logic [1:0] ERR_CLEN   = 2'd2;
  localparam logic [1:0] ERR_TRUNC  = 2'd3;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MAX_CHANNEL = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH  = 2'd1;
  localparam logic [1:0] REG_IGNORE_ERR  = 2'd2;

  localparam logic [8:0] TEXT_CHANNEL = 9'd256;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [8:0] channel;
    logic       last;
    logic       status_ok;
    logic [1:0] error_code;
  } res_t;

  // push bundle from parser to result queue
  typedef struct packed {
    logic [2:0] count;
    res_t [MAX_RES-1:0] items;
  } push_t;

  // characters of the content-length header name
  function automatic logic [7:0] cl_name(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic res_t mk_res(input logic kind, input logic [7:0] b,
                                  input logic [8:0] chan, input logic last,
                                  input logic ok, input logic [1:0] err);
    res_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.channel    = chan;
    r.last       = last;
    r.status_ok  = ok;
    r.error_code = err;
    return r;
  endfunction

endpackage

/* rtl/rtspd_stream_if.sv */
// stream channel interfaces for input bytes and results
interface rtspd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface rtspd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [8:0] channel;
  logic       last;
  logic       status_ok;
  logic [1:0] error_code;
  modport source (output valid, kind, out_byte, channel, last, status_ok, error_code,
                  input ready);
  modport sink (input valid, kind, out_byte, channel, last, status_ok, error_code,
                output ready);
endinterface

/* rtl/rtspd_parser.sv */
// per-byte parser state and result generation
module rtspd_parser
  import rtspd_pkg::*;
#(
  parameter int BODY_LIMIT = BODY_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        proc,
  input  logic [7:0]  data_byte,
  input  logic        eos,
  input  logic [7:0]  max_channel,
  input  logic [15:0] max_length,
  input  logic        resume_on_err,
  output push_t       push
);

  localparam int LIM_W = $clog2(BODY_LIMIT + 1);
  localparam int ACC_W = (LIM_W > 17) ? LIM_W : 17;
  localparam logic [ACC_W+3:0] CODE_CAP = (ACC_W+4)'(32'h1FFFF);
  localparam logic [ACC_W+3:0] BODY_MAX = (ACC_W+4)'(BODY_LIMIT);

  logic [7:0]       win_r [4];
  logic [7:0]       win_nxt [4];
  logic [2:0]       fill_r, fill_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [7:0]       fchan_r, fchan_nxt;
  logic [ACC_W-1:0] left_r, left_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [3:0]       nmi_r, nmi_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             ok_r, ok_nxt;
  logic             empty_r, empty_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             pendv_r, pendv_nxt;
  logic             halted_r, halted_nxt;

  res_t       res [MAX_RES];
  logic [2:0] n;
  logic       err_fire, go_hunt, do_hunt;
  logic [1:0] err_code;
  logic [8:0] err_chan;
  logic       dg, ws, hws, delim, ender, opp;
  logic [7:0] b;
  logic [ACC_W+3:0] prod;
  logic [15:0] len;

  always_comb begin
    b     = data_byte;
    dg    = (b >= 8'h30) && (b <= 8'h39);
    ws    = (b == 8'h20) || (b == 8'h09);
    hws   = ws || (b == 8'h0b) || (b == 8'h0c);
    delim = ws || (b == 8'h3a);
    ender = (b == 8'h0d) || (b == 8'h0a);
    opp   = ((pend_r == 8'h0d) && (b == 8'h0a)) || ((pend_r == 8'h0a) && (b == 8'h0d));
    prod  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + (ACC_W+4)'(b - 8'h30);

    win_nxt    = win_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    fchan_nxt  = fchan_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    nmi_nxt    = nmi_r;
    acc_nxt    = acc_r;
    ok_nxt     = ok_r;
    empty_nxt  = empty_r;
    pend_nxt   = pend_r;
    pendv_nxt  = pendv_r;
    halted_nxt = halted_r;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    n        = 3'd0;
    err_fire = 1'b0;
    err_code = ERR_NONE;
    err_chan = TEXT_CHANNEL;
    go_hunt  = 1'b0;
    do_hunt  = 1'b0;
    len      = 16'd0;

    if (proc && !halted_r) begin
      if (eos) begin
        // end of stream: flush held ender or report a truncated frame
        if (mode_r == M_TAIL) begin
          res[n] = mk_res(KIND_DATA, pend_r, TEXT_CHANNEL, 1'b1, ok_r, ERR_NONE);
          n = n + 3'd1;
        end else if (mode_r == M_BIN) begin
          err_fire = 1'b1; err_code = ERR_TRUNC; err_chan = {1'b0, fchan_r};
        end else if (mode_r == M_STATUS || mode_r == M_HEADER || mode_r == M_BODY) begin
          err_fire = 1'b1; err_code = ERR_TRUNC;
        end
        go_hunt = 1'b1;
      end else begin
        unique case (mode_r)
          M_BIN: begin
            if (left_r != '0) left_nxt = left_r - 1'b1;
            res[n] = mk_res(KIND_DATA, b, {1'b0, fchan_r}, left_nxt == '0, 1'b0, ERR_NONE);
            n = n + 3'd1;
            if (left_nxt == '0) go_hunt = 1'b1;
          end
          M_STATUS: begin
            if (ender) begin
              if (phase_r == S_SLASH || phase_r == S_MAJ0 || phase_r == S_MAJ ||
                  phase_r == S_MIN0 || phase_r == S_POS || phase_r == S_NEG) begin
                err_fire = 1'b1;
              end else begin
                if (phase_r == S_CODE) ok_nxt = (acc_r == ACC_W'(200));
                mode_nxt  = M_HEADER;
                phase_nxt = H_LEAD;
                empty_nxt = 1'b1;
                pend_nxt  = b;
                pendv_nxt = 1'b1;
              end
            end else begin
              case (phase_r)
                S_SLASH: if (b != 8'h2f) err_fire = 1'b1; else phase_nxt = S_MAJ0;
                S_MAJ0:  if (!dg) err_fire = 1'b1; else phase_nxt = S_MAJ;
                S_MAJ: begin
                  if (b == 8'h2e) phase_nxt = S_MIN0;
                  else if (!dg) err_fire = 1'b1;
                end
                S_MIN0:  if (!dg) err_fire = 1'b1; else phase_nxt = S_MIN;
                S_MIN: begin
                  if (ws) phase_nxt = S_GAP;
                  else if (!dg) phase_nxt = S_VTAIL;
                end
                S_VTAIL: if (ws) phase_nxt = S_GAP;
                S_GAP: begin
                  if (dg) begin
                    acc_nxt = ACC_W'(b - 8'h30); phase_nxt = S_CODE;
                  end else if (b == 8'h2b) phase_nxt = S_POS;
                  else if (b == 8'h2d) phase_nxt = S_NEG;
                  else if (!ws) err_fire = 1'b1;
                end
                S_POS: begin
                  if (!dg) err_fire = 1'b1;
                  else begin
                    acc_nxt = ACC_W'(b - 8'h30); phase_nxt = S_CODE;
                  end
                end
                S_NEG: if (!dg) err_fire = 1'b1; else phase_nxt = S_CTAIL;
                S_CODE: begin
                  if (dg) acc_nxt = (prod > CODE_CAP) ? ACC_W'(CODE_CAP) : ACC_W'(prod);
                  else begin
                    ok_nxt = (acc_r == ACC_W'(200)); phase_nxt = S_CTAIL;
                  end
                end
                default: ;
              endcase
            end
            if (err_fire) err_code = ERR_STATUS;
            else begin
              res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
            end
          end
          M_HEADER: begin
            if (pendv_r && opp) begin
              // absorbed partner of the previous line ender
              pendv_nxt = 1'b0;
              res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
            end else begin
              pendv_nxt = 1'b0;
              if (ender) begin
                if (empty_r) begin
                  pend_nxt  = b;
                  pendv_nxt = 1'b1;
                  if (left_r == '0) mode_nxt = M_TAIL;
                  else begin
                    mode_nxt = M_BODY;
                    res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
                    n = n + 3'd1;
                  end
                end else if (phase_r == H_VLEAD || phase_r == H_VSIGN ||
                             (phase_r == H_NAME && nmi_r == NAME_LEN)) begin
                  err_fire = 1'b1; err_code = ERR_CLEN;
                end else begin
                  if (phase_r == H_VNUM) left_nxt = acc_r;
                  phase_nxt = H_LEAD;
                  empty_nxt = 1'b1;
                  pend_nxt  = b;
                  pendv_nxt = 1'b1;
                  res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
                  n = n + 3'd1;
                end
              end else begin
                empty_nxt = 1'b0;
                case (phase_r)
                  H_LEAD: begin
                    if (!delim) begin
                      nmi_nxt   = (b == cl_name(4'd0)) ? 4'd1 : NO_MATCH;
                      phase_nxt = H_NAME;
                    end
                  end
                  H_NAME: begin
                    if (delim) phase_nxt = (nmi_r == NAME_LEN) ? H_VLEAD : H_SKIP;
                    else if (nmi_r < NAME_LEN && b == cl_name(nmi_r)) nmi_nxt = nmi_r + 4'd1;
                    else nmi_nxt = NO_MATCH;
                  end
                  H_VLEAD: begin
                    if (dg) begin
                      acc_nxt = ACC_W'(b - 8'h30); phase_nxt = H_VNUM;
                    end else if (b == 8'h2b) phase_nxt = H_VSIGN;
                    else if (!hws) err_fire = 1'b1;
                  end
                  H_VSIGN: begin
                    if (!dg) err_fire = 1'b1;
                    else begin
                      acc_nxt = ACC_W'(b - 8'h30); phase_nxt = H_VNUM;
                    end
                  end
                  H_VNUM: begin
                    if (!dg || prod > BODY_MAX) err_fire = 1'b1;
                    else acc_nxt = ACC_W'(prod);
                  end
                  default: ;
                endcase
                if (err_fire) err_code = ERR_CLEN;
                else begin
                  res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
                  n = n + 3'd1;
                end
              end
            end
          end
          M_BODY: begin
            if (pendv_r && opp) begin
              pendv_nxt = 1'b0;
              res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
            end else begin
              pendv_nxt = 1'b0;
              if (left_r != '0) left_nxt = left_r - 1'b1;
              res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, left_nxt == '0,
                              (left_nxt == '0) && ok_r, ERR_NONE);
              n = n + 3'd1;
              if (left_nxt == '0) go_hunt = 1'b1;
            end
          end
          M_TAIL: begin
            if (opp) begin
              res[n] = mk_res(KIND_DATA, pend_r, TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
              res[n] = mk_res(KIND_DATA, b, TEXT_CHANNEL, 1'b1, ok_r, ERR_NONE);
              n = n + 3'd1;
              go_hunt = 1'b1;
            end else begin
              res[n] = mk_res(KIND_DATA, pend_r, TEXT_CHANNEL, 1'b1, ok_r, ERR_NONE);
              n = n + 3'd1;
              go_hunt = 1'b1;
              do_hunt = 1'b1;
            end
          end
          default: do_hunt = 1'b1;
        endcase
      end

      // error notice, then halt or resume hunting
      if (err_fire) begin
        res[n] = mk_res(KIND_ERROR, 8'h00, err_chan, 1'b1, 1'b0, err_code);
        n = n + 3'd1;
        if (!resume_on_err) halted_nxt = 1'b1;
        go_hunt = 1'b1;
      end
      if (go_hunt) begin
        mode_nxt  = M_HUNT;
        fill_nxt  = 3'd0;
        pendv_nxt = 1'b0;
        phase_nxt = 4'd0;
        nmi_nxt   = 4'd0;
        acc_nxt   = '0;
      end

      // four-byte hunt window
      if (do_hunt) begin
        win_nxt[fill_nxt[1:0]] = b;
        if (fill_nxt == 3'd3) begin
          len = {win_nxt[2], win_nxt[3]};
          if (win_nxt[0] == 8'h24 && win_nxt[1] <= max_channel && len <= max_length) begin
            fchan_nxt = win_nxt[1];
            left_nxt  = ACC_W'(len);
            fill_nxt  = 3'd0;
            if (len != 16'd0) mode_nxt = M_BIN;
          end else if (win_nxt[0] == 8'h52 && win_nxt[1] == 8'h54 &&
                       win_nxt[2] == 8'h53 && win_nxt[3] == 8'h50) begin
            for (int i = 0; i < 4; i++) begin
              res[n] = mk_res(KIND_DATA, win_nxt[i], TEXT_CHANNEL, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
            end
            fill_nxt  = 3'd0;
            mode_nxt  = M_STATUS;
            phase_nxt = S_SLASH;
            ok_nxt    = 1'b0;
            left_nxt  = '0;
            empty_nxt = 1'b0;
            pendv_nxt = 1'b0;
            acc_nxt   = '0;
          end else begin
            win_nxt[0] = win_nxt[1];
            win_nxt[1] = win_nxt[2];
            win_nxt[2] = win_nxt[3];
            fill_nxt   = 3'd3;
          end
        end else begin
          fill_nxt = fill_nxt + 3'd1;
        end
      end
    end

    push.count = n;
    for (int i = 0; i < MAX_RES; i++) push.items[i] = res[i];
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) win_r[i] <= 8'h00;
      fill_r   <= 3'd0;
      mode_r   <= M_HUNT;
      fchan_r  <= 8'h00;
      left_r   <= '0;
      phase_r  <= 4'd0;
      nmi_r    <= 4'd0;
      acc_r    <= '0;
      ok_r     <= 1'b0;
      empty_r  <= 1'b1;
      pend_r   <= 8'h00;
      pendv_r  <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      win_r    <= win_nxt;
      fill_r   <= fill_nxt;
      mode_r   <= mode_nxt;
      fchan_r  <= fchan_nxt;
      left_r   <= left_nxt;
      phase_r  <= phase_nxt;
      nmi_r    <= nmi_nxt;
      acc_r    <= acc_nxt;
      ok_r     <= ok_nxt;
      empty_r  <= empty_nxt;
      pend_r   <= pend_nxt;
      pendv_r  <= pendv_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* rtl/rtspd_fifo.sv */
// result queue taking up to five results per cycle and giving one
module rtspd_fifo
  import rtspd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int AW = $clog2(FIFO_DEPTH);

  res_t        mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (AW+1)'(FIFO_DEPTH - MAX_RES));
  assign cnt_nxt   = cnt_r + (AW+1)'(push.count) - (AW+1)'(pop);

  // storage writes
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (3'(k) < push.count) mem_r[wr_r + AW'(k)] <= push.items[k];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(push.count);
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/rtsp_interleaved_stream_demux_unit.sv */
// top level of the rtsp interleaved stream demux
//
// Splits an rtsp-over-tcp byte stream into binary frame payloads tagged with
// their channel and rtsp text messages tagged 256.
// in_if: one byte (or an end-of-stream mark) per transfer on valid/ready.
// out_if: one result per transfer: data byte or error notice with tags.
// cfg_*: apb write/read of max_channel (0x0), max_length (0x4) and
// resume_on_err (0x8); pready is always high.
// An accepted byte lands in an input register and is parsed from there
// once the queue has room; its results are stored in the queue and offered.
// Throughput: one byte per cycle while each byte gives at most one result and
// results are taken; a byte that gives several results (up to five) holds
// later bytes back while the eight-entry single-read result queue drains.
// A byte is parsed only when the queue has room for five results.
// Reset clears the parser to hunting, empties the queue and loads the
// register defaults. A stalled receiver fills the queue and then holds
// in_if.ready low; nothing is dropped.
module rtsp_interleaved_stream_demux_unit
  import rtspd_pkg::*;
#(
  parameter int BODY_LIMIT = BODY_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rtspd_in_if.sink    in_if,
  rtspd_out_if.source out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]  max_channel_r;
  logic [15:0] max_length_r;
  logic        resume_on_err_r;
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_eos_r;
  logic        room, proc, wr_en;
  push_t       push;
  res_t        out_res;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_channel_r   <= 8'd16;
      max_length_r    <= 16'd2048;
      resume_on_err_r <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_MAX_CHANNEL: max_channel_r   <= cfg_pwdata[7:0];
        REG_MAX_LENGTH:  max_length_r    <= cfg_pwdata[15:0];
        REG_IGNORE_ERR:  resume_on_err_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MAX_CHANNEL: cfg_prdata = {24'd0, max_channel_r};
      REG_MAX_LENGTH:  cfg_prdata = {16'd0, max_length_r};
      REG_IGNORE_ERR:  cfg_prdata = {31'd0, resume_on_err_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // input register
  assign proc        = in_v_r && room;
  assign in_if.ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
      in_eos_r  <= in_if.end_of_stream;
    end
  end

  rtspd_parser #(
    .BODY_LIMIT (BODY_LIMIT)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .proc          (proc),
    .data_byte     (in_byte_r),
    .eos           (in_eos_r),
    .max_channel   (max_channel_r),
    .max_length    (max_length_r),
    .resume_on_err (resume_on_err_r),
    .push          (push)
  );

  rtspd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  // result payload
  assign out_if.kind       = out_res.kind;
  assign out_if.out_byte   = out_res.out_byte;
  assign out_if.channel    = out_res.channel;
  assign out_if.last       = out_res.last;
  assign out_if.status_ok  = out_res.status_ok;
  assign out_if.error_code = out_res.error_code;

endmodule

/* rtl/rtspd_chk.sv */
// port-level checker for the rtsp stream demux, bound to the top level
module rtspd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] out_byte,
  input logic [8:0] channel,
  input logic       last,
  input logic       status_ok,
  input logic [1:0] error_code
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result offered after reset");

  // an error notice closes its frame and carries no byte
  a_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind |-> last && out_byte == 8'h00 && error_code != 2'd0)
    else $error("malformed error notice");

  // data carries no error code, and status_ok only on a text message end
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !kind |-> error_code == 2'd0 && (!status_ok || (last && channel == 9'd256)))
    else $error("malformed data result");

  // channel never above the text tag
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && channel[8] |-> channel[7:0] == 8'h00)
    else $error("channel out of range");

endmodule

bind rtsp_interleaved_stream_demux_unit rtspd_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .kind       (out_if.kind),
  .out_byte   (out_if.out_byte),
  .channel    (out_if.channel),
  .last       (out_if.last),
  .status_ok  (out_if.status_ok),
  .error_code (out_if.error_code)
);
